### rtl/encoder_dpad_scale_offset_ctrl_macros.svh
// Assertion macros shared by the encoder and pad controller RTL.
`ifndef ENCODER_DPAD_SCALE_OFFSET_CTRL_MACROS_SVH
`define ENCODER_DPAD_SCALE_OFFSET_CTRL_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every edge out of reset
`define EDSOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must hold in the cycle after a trigger
`define EDSOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EDSOC_ASSERT(lbl, prop, msg)
`define EDSOC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/edsoc_pkg.sv
// Types, constants and the step table of the encoder and pad controller.
package edsoc_pkg;

  localparam int unsigned OffsetWidth  = 32;
  localparam int unsigned StepWidth    = OffsetWidth + 1;
  localparam int unsigned OutOffWidth  = 32;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned MsWidth      = 16;
  localparam int unsigned ScaleWidth   = 6;
  localparam int unsigned ScaleCodes   = 1 << ScaleWidth;
  localparam int unsigned ModeWidth    = 2;
  localparam int unsigned CfgIdxWidth  = 8;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned FifoDepth    = 2;
  localparam int unsigned FifoPtrWidth = $clog2(FifoDepth);
  localparam int unsigned FifoCntWidth = $clog2(FifoDepth + 1);

  // Register reset values
  localparam logic [MsWidth-1:0]    HoldDelayRst  = MsWidth'(750);
  localparam logic [MsWidth-1:0]    RepeatRst     = MsWidth'(250);
  localparam logic [ScaleWidth-1:0] ScaleLimitRst = ScaleWidth'(35);

  // Adjust mode codes: bit 0 enables Y, bit 1 enables X
  localparam logic [ModeWidth-1:0] ModeNone = 2'd0;
  localparam logic [ModeWidth-1:0] ModeY    = 2'd1;
  localparam logic [ModeWidth-1:0] ModeX    = 2'd2;
  localparam logic [ModeWidth-1:0] ModeBoth = 2'd3;

  // Quadrature levels {A,B}
  localparam logic [1:0] AbRest = 2'b00;
  localparam logic [1:0] AbDec  = 2'b10;
  localparam logic [1:0] AbInc  = 2'b01;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegHoldDelay      = 8'd0,
    RegRepeatInterval = 8'd1,
    RegScaleLimit     = 8'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DirNone,
    DirLeft,
    DirRight,
    DirUp,
    DirDown
  } dir_e;

  // Classified poll word passed from front to back
  typedef struct packed {
    logic [TimeWidth-1:0]  time_ms;
    dir_e                  dir;
    logic                  center;
    logic [StepWidth-1:0]  step;
    logic [ScaleWidth-1:0] scale_x;
    logic [ScaleWidth-1:0] scale_y;
    logic [ModeWidth-1:0]  mode;
  } cmd_t;

  typedef struct packed {
    logic [MsWidth-1:0]    hold_delay;
    logic [MsWidth-1:0]    repeat_interval;
    logic [ScaleWidth-1:0] scale_limit;
  } cfg_t;

  typedef logic [StepWidth-1:0] step_lut_t [ScaleCodes];

  // (1 << (c & 3)) * 10^(c >> 2), capped at 2^OffsetWidth (codes 39 and up saturate there)
  function automatic step_lut_t build_step_lut();
    step_lut_t   lut;
    logic [64:0] v;
    logic [64:0] cap;
    cap = 65'(1) << OffsetWidth;
    for (int c = 0; c < ScaleCodes; c++) begin
      v = 65'(1) << (c & 3);
      for (int d = 0; d < (c >> 2); d++) begin
        v = v * 65'd10;
      end
      if (v > cap) begin
        v = cap;
      end
      lut[c] = v[StepWidth-1:0];
    end
    return lut;
  endfunction

  localparam step_lut_t StepLut = build_step_lut();

  // Offset to output width, sign extended or truncated
  function automatic logic [OutOffWidth-1:0] offset_to_out(logic signed [OffsetWidth-1:0] v);
    logic signed [OffsetWidth+OutOffWidth-1:0] w;
    w = (OffsetWidth + OutOffWidth)'(v);
    return w[OutOffWidth-1:0];
  endfunction

endpackage

### rtl/edsoc_if.sv
// Channel interfaces: poll words in, result words out, register writes.
interface edsoc_in_if import edsoc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TimeWidth-1:0] time_ms;
  logic                 push_level;
  logic                 enc_a;
  logic                 enc_b;
  logic                 left_level;
  logic                 right_level;
  logic                 up_level;
  logic                 down_level;
  logic                 center_level;

  modport source (output valid, time_ms, push_level, enc_a, enc_b, left_level,
                  right_level, up_level, down_level, center_level, input ready);
  modport sink   (input valid, time_ms, push_level, enc_a, enc_b, left_level,
                  right_level, up_level, down_level, center_level, output ready);
endinterface

interface edsoc_out_if import edsoc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [ScaleWidth-1:0]         scale_x_code;
  logic [ScaleWidth-1:0]         scale_y_code;
  logic signed [OutOffWidth-1:0] offset_x_value;
  logic signed [OutOffWidth-1:0] offset_y_value;
  logic [ModeWidth-1:0]          mode_bits;

  modport source (output valid, scale_x_code, scale_y_code, offset_x_value,
                  offset_y_value, mode_bits, input ready);
  modport sink   (input valid, scale_x_code, scale_y_code, offset_x_value,
                  offset_y_value, mode_bits, output ready);
endinterface

interface edsoc_cfg_if import edsoc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/edsoc_fifo.sv
// Short queue of classified poll words between front and back.
`include "encoder_dpad_scale_offset_ctrl_macros.svh"

module edsoc_fifo import edsoc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t                    mem_q [FifoDepth];
  logic [FifoPtrWidth-1:0] wptr_q, wptr_d;
  logic [FifoPtrWidth-1:0] rptr_q, rptr_d;
  logic [FifoCntWidth-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FifoCntWidth'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == FifoPtrWidth'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == FifoPtrWidth'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `EDSOC_ASSERT(a_no_overflow, !(push_i && full_o), "queue written while full")
  `EDSOC_ASSERT(a_no_underflow, !(pop_i && empty_o), "queue read while empty")
  `EDSOC_ASSERT(a_cnt_in_range, cnt_q <= FifoCntWidth'(FifoDepth), "queue count out of range")

endmodule

### rtl/edsoc_front.sv
// Front end: takes poll words, runs the encoder and classifies the pad.
`include "encoder_dpad_scale_offset_ctrl_macros.svh"

module edsoc_front import edsoc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  edsoc_in_if.sink              in_i,
  input  logic [ScaleWidth-1:0] scale_limit_i,
  input  logic                  full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [ModeWidth-1:0]  mode_q, mode_d;
  logic                  latched_q, latched_d;
  logic [1:0]            last_ab_q, last_ab_d;
  logic [ScaleWidth-1:0] sx_q, sx_d;
  logic [ScaleWidth-1:0] sy_q, sy_d;
  logic                  pressed;
  logic [1:0]            ab;
  logic                  enc_dec;
  logic                  enc_inc;
  dir_e                  dir;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Encoder: push edge steps the mode, detents step the enabled scales
  always_comb begin
    pressed   = !in_i.push_level;
    ab        = {in_i.enc_a, in_i.enc_b};
    mode_d    = mode_q;
    latched_d = pressed;
    last_ab_d = ab;
    sx_d      = sx_q;
    sy_d      = sy_q;
    if (pressed && !latched_q) begin
      mode_d = (mode_q == ModeY) ? ModeBoth : mode_q - 2'd1;
    end
    enc_dec = (last_ab_q == AbDec) && (ab == AbRest);
    enc_inc = (last_ab_q == AbInc) && (ab == AbRest);
    if (enc_dec) begin
      if (mode_d[0] && (sy_q != '0)) sy_d = sy_q - 1'b1;
      if (mode_d[1] && (sx_q != '0)) sx_d = sx_q - 1'b1;
    end else if (enc_inc) begin
      if (mode_d[0] && (sy_q < scale_limit_i)) sy_d = sy_q + 1'b1;
      if (mode_d[1] && (sx_q < scale_limit_i)) sx_d = sx_q + 1'b1;
    end
  end

  // Pad direction by priority
  always_comb begin
    priority if (!in_i.left_level)  dir = DirLeft;
    else if (!in_i.right_level)     dir = DirRight;
    else if (!in_i.up_level)        dir = DirUp;
    else if (!in_i.down_level)      dir = DirDown;
    else                            dir = DirNone;
  end

  // Classified word for the back end
  always_comb begin
    cmd_o.time_ms = in_i.time_ms;
    cmd_o.dir     = dir;
    cmd_o.center  = !in_i.center_level;
    cmd_o.scale_x = sx_d;
    cmd_o.scale_y = sy_d;
    cmd_o.mode    = mode_d;
    unique case (dir)
      DirLeft, DirRight: cmd_o.step = StepLut[sx_d];
      DirUp, DirDown:    cmd_o.step = StepLut[sy_d];
      default:           cmd_o.step = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeBoth;
      latched_q <= 1'b0;
      last_ab_q <= AbRest;
      sx_q      <= '0;
      sy_q      <= '0;
    end else if (push_o) begin
      mode_q    <= mode_d;
      latched_q <= latched_d;
      last_ab_q <= last_ab_d;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
    end
  end

  `EDSOC_ASSERT(a_mode_nonzero, mode_q != ModeNone, "adjust mode reached zero")
  `EDSOC_ASSERT_NEXT(a_idle_holds_mode, !push_o, $stable(mode_q) && $stable(sx_q),
    "encoder state moved without a word")

endmodule

### rtl/edsoc_back.sv
// Back end: pad hold and repeat timing, saturating offsets, result register.
`include "encoder_dpad_scale_offset_ctrl_macros.svh"

module edsoc_back import edsoc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  edsoc_out_if.source out_o
);

  localparam logic signed [OffsetWidth-1:0] OffMax = {1'b0, {(OffsetWidth - 1){1'b1}}};
  localparam logic signed [OffsetWidth-1:0] OffMin = {1'b1, {(OffsetWidth - 1){1'b0}}};

  logic signed [OffsetWidth-1:0] offx_q, offx_d;
  logic signed [OffsetWidth-1:0] offy_q, offy_d;
  logic                          held_q, held_d;
  logic [TimeWidth-1:0]          press_q, press_d;
  logic [TimeWidth-1:0]          last_q, last_d;
  logic                          out_valid_q;
  logic [TimeWidth-1:0]          since_press;
  logic [TimeWidth-1:0]          since_step;
  logic                          due;

  // Add or subtract a step, clamped to the signed offset range
  function automatic logic signed [OffsetWidth-1:0] sat_step(
    logic signed [OffsetWidth-1:0] a, logic [StepWidth-1:0] s, logic sub);
    logic signed [OffsetWidth+1:0] sum;
    logic signed [OffsetWidth+1:0] se;
    se  = $signed({1'b0, s});
    sum = sub ? (OffsetWidth + 2)'(a) - se : (OffsetWidth + 2)'(a) + se;
    if (sum > (OffsetWidth + 2)'(OffMax)) begin
      return OffMax;
    end else if (sum < (OffsetWidth + 2)'(OffMin)) begin
      return OffMin;
    end
    return $signed(sum[OffsetWidth-1:0]);
  endfunction

  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || out_o.ready);

  // Repeat window: open when nothing is held, else after hold and interval
  always_comb begin
    since_press = cmd_i.time_ms - press_q;
    since_step  = cmd_i.time_ms - last_q;
    due = !held_q ||
          ((since_press > TimeWidth'(cfg_i.hold_delay)) &&
           (since_step > TimeWidth'(cfg_i.repeat_interval)));
  end

  // Pad step and centre clear
  always_comb begin
    offx_d  = offx_q;
    offy_d  = offy_q;
    held_d  = held_q;
    press_d = press_q;
    last_d  = last_q;
    if (due) begin
      if (!held_q) press_d = cmd_i.time_ms;
      last_d = cmd_i.time_ms;
      held_d = 1'b1;
      unique case (cmd_i.dir)
        DirLeft:  offx_d = sat_step(offx_q, cmd_i.step, 1'b1);
        DirRight: offx_d = sat_step(offx_q, cmd_i.step, 1'b0);
        DirUp:    offy_d = sat_step(offy_q, cmd_i.step, 1'b0);
        DirDown:  offy_d = sat_step(offy_q, cmd_i.step, 1'b1);
        default:  held_d = 1'b0;
      endcase
    end
    if (cmd_i.center) begin
      offx_d = '0;
      offy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offx_q  <= '0;
      offy_q  <= '0;
      held_q  <= 1'b0;
      press_q <= '0;
      last_q  <= '0;
    end else if (cmd_pop_o) begin
      offx_q  <= offx_d;
      offy_q  <= offy_d;
      held_q  <= held_d;
      press_q <= press_d;
      last_q  <= last_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_o.scale_x_code   <= cmd_i.scale_x;
      out_o.scale_y_code   <= cmd_i.scale_y;
      out_o.offset_x_value <= $signed(offset_to_out(offx_d));
      out_o.offset_y_value <= $signed(offset_to_out(offy_d));
      out_o.mode_bits      <= cmd_i.mode;
    end
  end

  assign out_o.valid = out_valid_q;

  `EDSOC_ASSERT_NEXT(a_pop_loads_out, cmd_pop_o, out_valid_q, "popped word left no result")
  `EDSOC_ASSERT_NEXT(a_stall_holds_pad, !cmd_pop_o, $stable(offx_q) && $stable(held_q),
    "pad state moved without a word")

endmodule

### rtl/encoder_dpad_scale_offset_ctrl.sv
// Top level of the encoder and direction pad controller.
//
//  port   dir  role                         width of word
//  in_i   in   poll word: time and pins     32 + 8 bits
//  out_o  out  result: scales, offsets, mode 6+6+32+32+2 bits
//  cfg_i  in   register write: index, data  8 + 16 bits
//
// One poll word per cycle while the queue has room; each accepted word passes
// through the queue, is popped by the back end and lands in the result register,
// where it is held valid until the receiver takes it.
// The front end runs the encoder state; the back end owns pad timing and offsets.
// A two-word queue lets the front keep taking words while the result waits;
// the poll input stalls only while the queue is full.
// Reset is immediate: no clearing pass. Register writes are always taken.
module encoder_dpad_scale_offset_ctrl import edsoc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  edsoc_in_if.sink    in_i,
  edsoc_out_if.source out_o,
  edsoc_cfg_if.sink   cfg_i
);

  cfg_t cfg_q;
  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_delay      <= HoldDelayRst;
      cfg_q.repeat_interval <= RepeatRst;
      cfg_q.scale_limit     <= ScaleLimitRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        RegHoldDelay:      cfg_q.hold_delay      <= cfg_i.data[MsWidth-1:0];
        RegRepeatInterval: cfg_q.repeat_interval <= cfg_i.data[MsWidth-1:0];
        RegScaleLimit:     cfg_q.scale_limit     <= cfg_i.data[ScaleWidth-1:0];
        default:           ;
      endcase
    end
  end

  edsoc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .scale_limit_i (cfg_q.scale_limit),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  edsoc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  edsoc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (pop_cmd),
    .cmd_valid_i (!empty),
    .cmd_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

### verif/tb_encoder_dpad_scale_offset_ctrl.sv
// Testbench for the encoder and pad controller: random polls checked against a scale/offset tracker.
module tb_encoder_dpad_scale_offset_ctrl import edsoc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 8;

  // Pad press masks, one bit per direction
  localparam logic [3:0] PadNone  = 4'b0000;
  localparam logic [3:0] PadLeft  = 4'b0001;
  localparam logic [3:0] PadRight = 4'b0010;
  localparam logic [3:0] PadUp    = 4'b0100;
  localparam logic [3:0] PadDown  = 4'b1000;
  localparam logic [3:0] PadAll   = 4'b1111;
  localparam logic [3:0] PadDirs [4] = '{PadLeft, PadRight, PadUp, PadDown};

  // Both quadrature pins high: not a detent move
  localparam logic [1:0] AbBoth = 2'b11;
  // Index past the register list
  localparam logic [CfgIdxWidth-1:0] RegUnused = 8'hFF;

  typedef struct {
    logic [TimeWidth-1:0] time_ms;
    logic push_level;
    logic enc_a;
    logic enc_b;
    logic left_level;
    logic right_level;
    logic up_level;
    logic down_level;
    logic center_level;
  } poll_t;

  typedef struct {
    logic [ScaleWidth-1:0]  scale_x_code;
    logic [ScaleWidth-1:0]  scale_y_code;
    logic [OutOffWidth-1:0] offset_x_value;
    logic [OutOffWidth-1:0] offset_y_value;
    logic [ModeWidth-1:0]   mode_bits;
  } reading_t;

  typedef struct {
    logic [CfgIdxWidth-1:0]  idx;
    logic [CfgDataWidth-1:0] data;
  } reg_write_t;

  // Tracks mode, scales, offsets and pad timing; queues the reading each poll gives
  class scale_offset_tracker;
    logic [MsWidth-1:0]    hold_ms;
    logic [MsWidth-1:0]    gap_ms;
    logic [ScaleWidth-1:0] scale_cap;
    logic [ModeWidth-1:0]  mode;
    logic [1:0]            last_ab;
    bit                    push_seen;
    logic [ScaleWidth-1:0] scale_x;
    logic [ScaleWidth-1:0] scale_y;
    longint                off_x;
    longint                off_y;
    bit                    pad_down;
    logic [TimeWidth-1:0]  press_t;
    logic [TimeWidth-1:0]  step_t;
    reading_t              pending_readings[$];
    int                    bad_words;

    function new();
      hold_ms   = HoldDelayRst;
      gap_ms    = RepeatRst;
      scale_cap = ScaleLimitRst;
      mode      = ModeBoth;
      last_ab   = AbRest;
      push_seen = 0;
      scale_x   = '0;
      scale_y   = '0;
      off_x     = 0;
      off_y     = 0;
      pad_down  = 0;
      press_t   = '0;
      step_t    = '0;
      bad_words = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      unique case (idx)
        RegHoldDelay:      hold_ms = data[MsWidth-1:0];
        RegRepeatInterval: gap_ms = data[MsWidth-1:0];
        RegScaleLimit:     scale_cap = data[ScaleWidth-1:0];
        default: ;
      endcase
    endfunction

    // (1 << mantissa) * 10^decade
    function longint step_size(logic [ScaleWidth-1:0] code);
      longint v;
      v = longint'(1) << code[1:0];
      repeat (code[5:2]) v = v * 10;
      return v;
    endfunction

    // Saturate to the signed offset range
    function longint clamp(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (OffsetWidth - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void take_poll(poll_t p);
      logic [1:0]           ab;
      logic [TimeWidth-1:0] since_press;
      logic [TimeWidth-1:0] since_step;
      reading_t             r;
      ab = {p.enc_a, p.enc_b};
      // push edge steps the mode 3, 2, 1, 3
      if (!p.push_level) begin
        if (!push_seen) begin
          mode = mode - 1'b1;
          if (mode == ModeNone) mode = ModeBoth;
          push_seen = 1;
        end
      end else begin
        push_seen = 0;
      end
      // detent moves back to rest
      if (last_ab == AbDec && ab == AbRest) begin
        if ((mode & ModeY) != 0 && scale_y != 0) scale_y--;
        if ((mode & ModeX) != 0 && scale_x != 0) scale_x--;
      end else if (last_ab == AbInc && ab == AbRest) begin
        if ((mode & ModeY) != 0 && scale_y < scale_cap) scale_y++;
        if ((mode & ModeX) != 0 && scale_x < scale_cap) scale_x++;
      end
      last_ab = ab;
      // pad: immediate step, then autorepeat once the window opens
      since_press = p.time_ms - press_t;
      since_step  = p.time_ms - step_t;
      if (!pad_down || (since_press > hold_ms && since_step > gap_ms)) begin
        if (!pad_down) press_t = p.time_ms;
        step_t   = p.time_ms;
        pad_down = 1;
        if (!p.left_level)       off_x = clamp(off_x - step_size(scale_x));
        else if (!p.right_level) off_x = clamp(off_x + step_size(scale_x));
        else if (!p.up_level)    off_y = clamp(off_y + step_size(scale_y));
        else if (!p.down_level)  off_y = clamp(off_y - step_size(scale_y));
        else                     pad_down = 0;
      end
      if (!p.center_level) begin
        off_x = 0;
        off_y = 0;
      end
      r.scale_x_code   = scale_x;
      r.scale_y_code   = scale_y;
      r.offset_x_value = off_x[OutOffWidth-1:0];
      r.offset_y_value = off_y[OutOffWidth-1:0];
      r.mode_bits      = mode;
      pending_readings.push_back(r);
    endfunction

    function void match_reading(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        $error("result word with no poll outstanding");
        bad_words++;
        return;
      end
      want = pending_readings.pop_front();
      if (got.scale_x_code !== want.scale_x_code) begin
        $error("scale_x_code: expected %0d, got %0d", want.scale_x_code, got.scale_x_code);
        bad_words++;
      end
      if (got.scale_y_code !== want.scale_y_code) begin
        $error("scale_y_code: expected %0d, got %0d", want.scale_y_code, got.scale_y_code);
        bad_words++;
      end
      if (got.offset_x_value !== want.offset_x_value) begin
        $error("offset_x_value: expected %0d, got %0d",
               $signed(want.offset_x_value), $signed(got.offset_x_value));
        bad_words++;
      end
      if (got.offset_y_value !== want.offset_y_value) begin
        $error("offset_y_value: expected %0d, got %0d",
               $signed(want.offset_y_value), $signed(got.offset_y_value));
        bad_words++;
      end
      if (got.mode_bits !== want.mode_bits) begin
        $error("mode_bits: expected %0d, got %0d", want.mode_bits, got.mode_bits);
        bad_words++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  edsoc_in_if  poll_if ();
  edsoc_out_if res_if ();
  edsoc_cfg_if cfg_if ();

  encoder_dpad_scale_offset_ctrl dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (poll_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  scale_offset_tracker tracker = new();

  // Generator state carried across phases
  logic [TimeWidth-1:0] cur_time = '0;
  bit                   enc_return = 0;
  int                   push_polls = 0;
  int                   pad_run = 0;
  logic [3:0]           pad_mask = PadNone;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("encoder_dpad_scale_offset_ctrl: mismatch");
    $finish;
  end

  // Receiver: ready follows a rotating stall mask, re-drawn now and then
  initial begin
    logic [7:0] stall_mask;
    logic [2:0] pos;
    int         hold_left;
    stall_mask = 8'hFF;
    pos = '0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0) begin
        hold_left  = $urandom_range(20, 120);
        stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        if (stall_mask == 8'h00) stall_mask = 8'h01;
      end
      hold_left--;
      res_if.ready <= stall_mask[pos];
      pos = pos + 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    reading_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.scale_x_code   = res_if.scale_x_code;
      got.scale_y_code   = res_if.scale_y_code;
      got.offset_x_value = res_if.offset_x_value;
      got.offset_y_value = res_if.offset_y_value;
      got.mode_bits      = res_if.mode_bits;
      tracker.match_reading(got);
    end
  end

  function automatic poll_t make_poll(logic [TimeWidth-1:0] t, bit push, logic [1:0] ab,
                                      logic [3:0] pads, bit center);
    poll_t p;
    p.time_ms      = t;
    p.push_level   = ~push;
    p.enc_a        = ab[1];
    p.enc_b        = ab[0];
    p.left_level   = ~pads[0];
    p.right_level  = ~pads[1];
    p.up_level     = ~pads[2];
    p.down_level   = ~pads[3];
    p.center_level = ~center;
    return p;
  endfunction

  function automatic reg_write_t reg_word(logic [CfgIdxWidth-1:0] idx,
                                          logic [CfgDataWidth-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    return w;
  endfunction

  // Scale limit word with random junk above the six code bits
  function automatic logic [CfgDataWidth-1:0] limit_word(logic [ScaleWidth-1:0] code);
    logic [CfgDataWidth-ScaleWidth-1:0] junk;
    junk = (CfgDataWidth - ScaleWidth)'($urandom);
    return {junk, code};
  endfunction

  // Always advances the clock before it checks for outstanding readings
  task automatic wait_drained();
    do @(posedge clk_i); while (tracker.pending_readings.size() != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes back to back, only while idle
  task automatic program_regs(input reg_write_t writes[$]);
    foreach (writes[k]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= writes[k].idx;
      cfg_if.data  <= writes[k].data;
      do @(posedge clk_i); while (!cfg_if.ready);
      tracker.write_reg(writes[k].idx, writes[k].data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Poll words in bursts with random gaps; now and then hold off until all readings are in
  task automatic send_stream(input poll_t polls[$]);
    int burst;
    int gap;
    bit drain;
    burst = 0;
    foreach (polls[k]) begin
      if (burst == 0) begin
        if (k > 0) begin
          drain = ($urandom_range(0, 39) == 0);
          gap   = $urandom_range(0, 5);
          if (drain || gap > 0) begin
            poll_if.valid <= 1'b0;
            if (drain) wait_drained();
            else repeat (gap) @(posedge clk_i);
          end
        end
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
      poll_if.valid        <= 1'b1;
      poll_if.time_ms      <= polls[k].time_ms;
      poll_if.push_level   <= polls[k].push_level;
      poll_if.enc_a        <= polls[k].enc_a;
      poll_if.enc_b        <= polls[k].enc_b;
      poll_if.left_level   <= polls[k].left_level;
      poll_if.right_level  <= polls[k].right_level;
      poll_if.up_level     <= polls[k].up_level;
      poll_if.down_level   <= polls[k].down_level;
      poll_if.center_level <= polls[k].center_level;
      do @(posedge clk_i); while (!poll_if.ready);
      tracker.take_poll(polls[k]);
      burst--;
    end
    poll_if.valid <= 1'b0;
  endtask

  // Mostly clean detents, short pushes and held pad runs; some pin noise
  task automatic run_random(int count, int inc_bias, int tstep_max);
    poll_t      polls[$];
    logic [1:0] ab;
    int         r;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) == 0) cur_time = $urandom;
      else cur_time = cur_time + $urandom_range(0, tstep_max);
      if (enc_return) begin
        ab = AbRest;
        enc_return = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        ab = 2'($urandom);
      end else if ($urandom_range(0, 2) == 0) begin
        ab = ($urandom_range(0, 99) < inc_bias) ? AbInc : AbDec;
        enc_return = 1;
      end else begin
        ab = AbRest;
      end
      if (push_polls > 0) push_polls--;
      else if ($urandom_range(0, 19) == 0) push_polls = $urandom_range(1, 3);
      if (pad_run == 0) begin
        pad_run = $urandom_range(1, 12);
        r = $urandom_range(0, 99);
        if (r < 40)      pad_mask = PadNone;
        else if (r < 85) pad_mask = PadDirs[$urandom_range(0, 3)];
        else             pad_mask = 4'($urandom);
      end
      pad_run--;
      polls.push_back(make_poll(cur_time, push_polls > 0, ab, pad_mask,
                                $urandom_range(0, 29) == 0));
    end
    send_stream(polls);
  endtask

  initial begin
    poll_t      directed[$];
    reg_write_t writes[$];
    int         hold_r;
    int         gap_r;

    rst_ni               <= 1'b0;
    poll_if.valid        <= 1'b0;
    poll_if.time_ms      <= '0;
    poll_if.push_level   <= 1'b1;
    poll_if.enc_a        <= 1'b0;
    poll_if.enc_b        <= 1'b0;
    poll_if.left_level   <= 1'b1;
    poll_if.right_level  <= 1'b1;
    poll_if.up_level     <= 1'b1;
    poll_if.down_level   <= 1'b1;
    poll_if.center_level <= 1'b1;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: encoder moves and stray transitions, mode cycling, pad timing, wrap
    directed.push_back(make_poll(32'd0, 0, AbRest, PadNone, 0));
    directed.push_back(make_poll(32'd1, 0, AbDec, PadNone, 0));
    directed.push_back(make_poll(32'd2, 0, AbRest, PadNone, 0));     // floor at zero
    directed.push_back(make_poll(32'd3, 0, AbInc, PadNone, 0));
    directed.push_back(make_poll(32'd4, 0, AbRest, PadNone, 0));
    directed.push_back(make_poll(32'd5, 0, AbBoth, PadNone, 0));
    directed.push_back(make_poll(32'd6, 0, AbRest, PadNone, 0));     // ignored move
    directed.push_back(make_poll(32'd7, 1, AbRest, PadNone, 0));
    directed.push_back(make_poll(32'd8, 1, AbInc, PadNone, 0));      // held push
    directed.push_back(make_poll(32'd9, 0, AbRest, PadNone, 0));     // X only
    directed.push_back(make_poll(32'd10, 1, AbRest, PadNone, 0));
    directed.push_back(make_poll(32'd11, 0, AbRest, PadNone, 0));
    directed.push_back(make_poll(32'd12, 1, AbRest, PadNone, 0));    // back to both
    directed.push_back(make_poll(32'd13, 0, AbRest, PadLeft, 0));
    directed.push_back(make_poll(32'd100, 0, AbRest, PadLeft, 0));
    directed.push_back(make_poll(32'd800, 0, AbRest, PadLeft, 0));   // first repeat
    directed.push_back(make_poll(32'd900, 0, AbRest, PadLeft, 0));
    directed.push_back(make_poll(32'd1100, 0, AbRest, PadNone, 0));  // release seen
    directed.push_back(make_poll(32'd1101, 0, AbRest, PadLeft | PadRight, 0));
    directed.push_back(make_poll(32'd1102, 0, AbRest, PadNone, 0));  // release hidden
    directed.push_back(make_poll(32'hFFFF_FF00, 0, AbRest, PadUp | PadDown, 0));
    directed.push_back(make_poll(32'h0000_0100, 0, AbRest, PadDown, 1));
    directed.push_back(make_poll(32'hFFFF_FFFF, 1, AbBoth, PadAll, 1));
    directed.push_back(make_poll(32'hFFFF_FFFF, 0, AbRest, PadNone, 0));
    send_stream(directed);
    settle();

    // No delays, widest limit, climbing scales: offsets saturate
    writes = {reg_word(RegHoldDelay, 16'd0), reg_word(RegRepeatInterval, 16'd0),
              reg_word(RegScaleLimit, limit_word(6'd63))};
    program_regs(writes);
    run_random(400, 80, 3);
    settle();

    // Longest delays, limit zero
    writes = {reg_word(RegHoldDelay, 16'hFFFF), reg_word(RegRepeatInterval, 16'hFFFF),
              reg_word(RegScaleLimit, limit_word(6'd0))};
    program_regs(writes);
    run_random(400, 50, 40000);
    settle();

    // Reset values again, plus a write past the register list
    writes = {reg_word(RegHoldDelay, 16'd750), reg_word(RegRepeatInterval, 16'd250),
              reg_word(RegScaleLimit, limit_word(6'd35)), reg_word(RegUnused, 16'($urandom))};
    program_regs(writes);
    run_random(400, 70, 400);
    settle();

    // Limit dropped under the current scales: they may only come down
    writes = {reg_word(RegScaleLimit, limit_word(6'd5)), reg_word(RegHoldDelay, 16'd20),
              reg_word(RegRepeatInterval, 16'd5)};
    program_regs(writes);
    run_random(400, 50, 30);
    settle();

    // Random settings
    hold_r = $urandom_range(0, 1000);
    gap_r  = $urandom_range(0, 1000);
    writes = {reg_word(RegHoldDelay, 16'(hold_r)), reg_word(RegRepeatInterval, 16'(gap_r)),
              reg_word(RegScaleLimit, limit_word(6'($urandom_range(0, 63))))};
    program_regs(writes);
    run_random(400, $urandom_range(20, 80), (hold_r > gap_r ? hold_r : gap_r) / 2 + 10);
    settle();

    repeat (16) @(posedge clk_i);
    foreach (tracker.pending_readings[k]) begin
      $error("reading never arrived: scale_x_code %0d",
             tracker.pending_readings[k].scale_x_code);
      tracker.bad_words++;
    end
    if (tracker.bad_words == 0) begin
      $display("encoder_dpad_scale_offset_ctrl: match");
    end else begin
      $display("encoder_dpad_scale_offset_ctrl: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/edsoc_pkg.sv
rtl/edsoc_if.sv
rtl/edsoc_fifo.sv
rtl/edsoc_front.sv
rtl/edsoc_back.sv
rtl/encoder_dpad_scale_offset_ctrl.sv
verif/tb_encoder_dpad_scale_offset_ctrl.sv
